// File: sv/tto_pkg.sv
`default_nettype none
package tto_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int WORD_BITS      = 48;
  localparam int NUM_PTS        = 7;
  localparam int NUM_DET        = 17;

  localparam logic [1:0] CAUSE_SEPARATED  = 2'd0;
  localparam logic [1:0] CAUSE_CORNER_IN  = 2'd1;
  localparam logic [1:0] CAUSE_STRADDLED  = 2'd2;
  localparam logic [1:0] CAUSE_DEGENERATE = 2'd3;

  // Point numbering: 0..2 triangle corners, 3..6 tetrahedron vertices.
  // Determinant 0 is the tetrahedron itself, 1 + 4*p + i has vertex i
  // replaced by triangle corner p, 13 + i is vertex i against the
  // triangle's plane.
  typedef logic [2:0] pt_idx_t;

  localparam pt_idx_t DET_PT [NUM_DET][4] = '{
    '{3'd3, 3'd4, 3'd5, 3'd6},
    '{3'd0, 3'd4, 3'd5, 3'd6}, '{3'd3, 3'd0, 3'd5, 3'd6},
    '{3'd3, 3'd4, 3'd0, 3'd6}, '{3'd3, 3'd4, 3'd5, 3'd0},
    '{3'd1, 3'd4, 3'd5, 3'd6}, '{3'd3, 3'd1, 3'd5, 3'd6},
    '{3'd3, 3'd4, 3'd1, 3'd6}, '{3'd3, 3'd4, 3'd5, 3'd1},
    '{3'd2, 3'd4, 3'd5, 3'd6}, '{3'd3, 3'd2, 3'd5, 3'd6},
    '{3'd3, 3'd4, 3'd2, 3'd6}, '{3'd3, 3'd4, 3'd5, 3'd2},
    '{3'd0, 3'd1, 3'd2, 3'd3}, '{3'd0, 3'd1, 3'd2, 3'd4},
    '{3'd0, 3'd1, 3'd2, 3'd5}, '{3'd0, 3'd1, 3'd2, 3'd6}
  };

  // Sign of a determinant, split into two flags.
  typedef struct packed {
    logic pos;
    logic neg;
  } sgn_t;

endpackage
`default_nettype wire

// File: sv/triangle_tetrahedron_overlap_test.sv
// Triangle / tetrahedron overlap test.
// Drive the seven corner words and pulse start; busy stays low, so a new
// word is taken on every clock edge at which start is high. Each corner
// word packs signed x, y, z of COORD_BITS each, x lowest; z bits beyond
// the 48-bit word read as zero.
// At the end of the pipeline, done goes high for one cycle with overlaps
// and cause for that word. Results leave in input order.
// Throughput is one word per cycle: all 17 orientation determinants run
// side by side through a six-stage pipeline (difference, cross-product
// multiply, cross-product subtract, dot-product multiply, sum and sign,
// verdict). The longest stage is one multiply of the cross component by
// an edge difference.
// cause: 0 separated, 1 corner inside, 2 plane straddled, 3 degenerate.
// The receiver cannot stall; results must be taken while done is high.
// Reset clears the valid bits, so no stale done leaves the pipeline.
`default_nettype none
module triangle_tetrahedron_overlap_test
  import tto_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [47:0] tri_corner_a,
  input  wire logic [47:0] tri_corner_b,
  input  wire logic [47:0] tri_corner_c,
  input  wire logic [47:0] tet_corner_a,
  input  wire logic [47:0] tet_corner_b,
  input  wire logic [47:0] tet_corner_c,
  input  wire logic [47:0] tet_corner_d,
  output logic             done,
  output logic             overlaps,
  output logic [1:0]       cause
);

  localparam int CB  = COORD_BITS;
  localparam int DW  = CB + 1;
  localparam int PW  = 2 * DW;
  localparam int CW  = PW + 1;
  localparam int QW  = CW + DW;
  localparam int SW  = QW + 2;
  localparam int XW  = WORD_BITS + 3 * CB;

  typedef logic signed [CB-1:0] crd_t;
  typedef logic signed [DW-1:0] dif_t;

  logic [WORD_BITS-1:0] words [NUM_PTS];
  crd_t px [NUM_PTS];
  crd_t py [NUM_PTS];
  crd_t pz [NUM_PTS];

  logic [5:0] vld;

  assign busy = 1'b0;

  assign words[0] = tri_corner_a;
  assign words[1] = tri_corner_b;
  assign words[2] = tri_corner_c;
  assign words[3] = tet_corner_a;
  assign words[4] = tet_corner_b;
  assign words[5] = tet_corner_c;
  assign words[6] = tet_corner_d;

  // Unpack coordinates; bits beyond the word read as zero
  for (genvar p = 0; p < NUM_PTS; p++) begin : g_unp
    logic [XW-1:0] wx;
    assign wx    = {{(3 * CB){1'b0}}, words[p]};
    assign px[p] = wx[CB-1:0];
    assign py[p] = wx[2*CB-1:CB];
    assign pz[p] = wx[3*CB-1:2*CB];
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[4:0], start};
    end
  end

  sgn_t sg [NUM_DET];
  logic nz3;

  for (genvar k = 0; k < NUM_DET; k++) begin : g_det
    dif_t ux, uy, uz, wx, wy, wz, qx, qy, qz;
    dif_t q2x, q2y, q2z, q3x, q3y, q3z;
    logic signed [PW-1:0] m0, m1, m2, m3, m4, m5;
    logic signed [CW-1:0] cx, cy, cz;
    logic signed [QW-1:0] dx, dy, dz;
    logic signed [SW-1:0] sm;

    assign sm = SW'(dx) + SW'(dy) + SW'(dz);

    always_ff @(posedge clk) begin
      // stage 1: edge differences from the first point
      ux <= dif_t'(px[DET_PT[k][1]]) - dif_t'(px[DET_PT[k][0]]);
      uy <= dif_t'(py[DET_PT[k][1]]) - dif_t'(py[DET_PT[k][0]]);
      uz <= dif_t'(pz[DET_PT[k][1]]) - dif_t'(pz[DET_PT[k][0]]);
      wx <= dif_t'(px[DET_PT[k][2]]) - dif_t'(px[DET_PT[k][0]]);
      wy <= dif_t'(py[DET_PT[k][2]]) - dif_t'(py[DET_PT[k][0]]);
      wz <= dif_t'(pz[DET_PT[k][2]]) - dif_t'(pz[DET_PT[k][0]]);
      qx <= dif_t'(px[DET_PT[k][3]]) - dif_t'(px[DET_PT[k][0]]);
      qy <= dif_t'(py[DET_PT[k][3]]) - dif_t'(py[DET_PT[k][0]]);
      qz <= dif_t'(pz[DET_PT[k][3]]) - dif_t'(pz[DET_PT[k][0]]);
      // stage 2: cross-product terms
      m0 <= PW'(uy) * PW'(wz);
      m1 <= PW'(uz) * PW'(wy);
      m2 <= PW'(uz) * PW'(wx);
      m3 <= PW'(ux) * PW'(wz);
      m4 <= PW'(ux) * PW'(wy);
      m5 <= PW'(uy) * PW'(wx);
      q2x <= qx;
      q2y <= qy;
      q2z <= qz;
      // stage 3: cross-product components
      cx <= CW'(m0) - CW'(m1);
      cy <= CW'(m2) - CW'(m3);
      cz <= CW'(m4) - CW'(m5);
      q3x <= q2x;
      q3y <= q2y;
      q3z <= q2z;
      // stage 4: dot-product terms
      dx <= QW'(cx) * QW'(q3x);
      dy <= QW'(cy) * QW'(q3y);
      dz <= QW'(cz) * QW'(q3z);
      // stage 5: sum and sign
      sg[k].pos <= (sm > 0);
      sg[k].neg <= (sm < 0);
    end

    // flag whether the triangle normal is nonzero, from the plane determinant
    if (k == NUM_DET - 4) begin : g_nrm
      always_ff @(posedge clk) begin
        nz3 <= (cx != '0) || (cy != '0) || (cz != '0);
      end
    end
  end

  logic nz4;
  logic [2:0] corner_hit;
  logic       all_pos, all_neg;

  // Hold the normal flag alongside the determinant signs
  always_ff @(posedge clk) begin
    nz4 <= nz3;
  end

  // Corner containment: the volume sign is nonzero and every face sign is zero or matches it
  for (genvar p = 0; p < 3; p++) begin : g_in
    logic [3:0] ok;
    for (genvar i = 0; i < 4; i++) begin : g_face
      assign ok[i] = (!sg[1+4*p+i].pos && !sg[1+4*p+i].neg) ||
                     (sg[1+4*p+i] == sg[0]);
    end
    assign corner_hit[p] = (sg[0].pos || sg[0].neg) && (&ok);
  end

  assign all_pos = sg[13].pos && sg[14].pos && sg[15].pos && sg[16].pos;
  assign all_neg = sg[13].neg && sg[14].neg && sg[15].neg && sg[16].neg;

  // stage 6: verdict
  always_ff @(posedge clk) begin
    if (|corner_hit) begin
      overlaps <= 1'b1;
      cause    <= CAUSE_CORNER_IN;
    end else if (!nz4) begin
      overlaps <= 1'b0;
      cause    <= CAUSE_DEGENERATE;
    end else if (all_pos || all_neg) begin
      overlaps <= 1'b0;
      cause    <= CAUSE_SEPARATED;
    end else begin
      overlaps <= 1'b1;
      cause    <= CAUSE_STRADDLED;
    end
  end

  assign done = vld[5];

endmodule
`default_nettype wire
